[sv/aeske_pkg.sv]
package aeske_pkg;

    // key length codes
    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    // first round constant and reduction term for doubling
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    // largest round count per key length
    localparam logic [3:0] MAX_NR_128 = 4'd10;
    localparam logic [3:0] MAX_NR_192 = 4'd12;
    localparam logic [3:0] MAX_NR_256 = 4'd14;

    // input item: one key with size code and round count
    typedef struct packed {
        logic [1:0]  key_size;
        logic [3:0]  rounds;
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
    } key_item_t;

    // result item: one round key
    typedef struct packed {
        logic [3:0]  round_index;
        logic [63:0] round_key_hi;
        logic [63:0] round_key_lo;
        logic        last_key;
    } rkey_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } state_t;

    // forward s-box
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // s-box on each byte of a word
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] r);
        gf_double = {r[6:0], 1'b0} ^ (r[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

[sv/aes_key_expansion_unit.sv]
// The first round key is registered once its four schedule words have been
// generated after the key transfer. One schedule word is generated per cycle
// through a single shared SubWord unit; a stalled round key output holds
// generation at the last word of the next round key.
// A new key is taken once the previous schedule has been fully generated.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops valid.
module aes_key_expansion_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    output logic                   key_stall,
    input  aeske_pkg::key_item_t   key_item,
    output logic                   rkey_valid,
    input  logic                   rkey_stall,
    output aeske_pkg::rkey_item_t  rkey_item
);

    aeske_pkg::state_t state_reg, state_next;

    logic [5:0]   word_cnt_reg, word_cnt_next;
    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [1:0]   size_reg, size_next;
    logic [3:0]   nr_reg, nr_next;
    logic [255:0] key_q_reg, key_q_next;
    logic [255:0] win_reg, win_next;
    logic [95:0]  quad_reg, quad_next;
    logic         out_valid_reg, out_valid_next;
    aeske_pkg::rkey_item_t out_reg, out_next;

    logic         key_xfer;
    logic         rkey_xfer;
    logic         step;
    logic         quad_end;
    logic         last_quad;
    logic [5:0]   nk;
    logic [2:0]   nk_last;
    logic         nk8;
    logic [3:0]   max_nr;
    logic [3:0]   nr_clamped;
    logic [31:0]  prev_word;
    logic [31:0]  back_word;
    logic [31:0]  sub_in;
    logic [31:0]  sub_out;
    logic [31:0]  temp_word;
    logic [31:0]  new_word;

    assign key_stall  = (state_reg != aeske_pkg::ST_IDLE);
    assign key_xfer   = key_valid && !key_stall;
    assign rkey_xfer  = out_valid_reg && !rkey_stall;
    assign rkey_valid = out_valid_reg;
    assign rkey_item  = out_reg;

    // clamp the requested round count to the key length
    always_comb
    begin
        case (key_item.key_size)
            aeske_pkg::KEY_128: max_nr = aeske_pkg::MAX_NR_128;
            aeske_pkg::KEY_192: max_nr = aeske_pkg::MAX_NR_192;
            default:            max_nr = aeske_pkg::MAX_NR_256;
        endcase
        nr_clamped = (key_item.rounds > max_nr) ? max_nr : key_item.rounds;
    end

    // key length decode for the running schedule
    always_comb
    begin
        case (size_reg)
            aeske_pkg::KEY_128:
            begin
                nk        = 6'd4;
                nk_last   = 3'd3;
                nk8       = 1'b0;
                back_word = win_reg[127:96];
            end
            aeske_pkg::KEY_192:
            begin
                nk        = 6'd6;
                nk_last   = 3'd5;
                nk8       = 1'b0;
                back_word = win_reg[191:160];
            end
            default:
            begin
                nk        = 6'd8;
                nk_last   = 3'd7;
                nk8       = 1'b1;
                back_word = win_reg[255:224];
            end
        endcase
    end

    // shared SubWord unit and next schedule word
    always_comb
    begin
        prev_word = win_reg[31:0];
        if (pos_reg == 3'd0)
        begin
            sub_in = {prev_word[23:0], prev_word[31:24]};
        end
        else
        begin
            sub_in = prev_word;
        end
        sub_out = aeske_pkg::sub_word(sub_in);
        if (pos_reg == 3'd0)
        begin
            temp_word = sub_out ^ {rcon_reg, 24'h000000};
        end
        else if (nk8 && pos_reg == 3'd4)
        begin
            temp_word = sub_out;
        end
        else
        begin
            temp_word = prev_word;
        end
        if (word_cnt_reg < nk)
        begin
            new_word = key_q_reg[255:224];
        end
        else
        begin
            new_word = back_word ^ temp_word;
        end
    end

    assign quad_end  = (word_cnt_reg[1:0] == 2'd3);
    assign last_quad = quad_end && (word_cnt_reg[5:2] == nr_reg);
    assign step      = (state_reg == aeske_pkg::ST_GEN)
                       && !(quad_end && out_valid_reg && rkey_stall);

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        pos_next       = pos_reg;
        rcon_next      = rcon_reg;
        size_next      = size_reg;
        nr_next        = nr_reg;
        key_q_next     = key_q_reg;
        win_next       = win_reg;
        quad_next      = quad_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (rkey_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            aeske_pkg::ST_IDLE:
            begin
                if (key_xfer)
                begin
                    state_next    = aeske_pkg::ST_GEN;
                    word_cnt_next = 6'd0;
                    pos_next      = 3'd0;
                    rcon_next     = aeske_pkg::RCON_FIRST;
                    size_next     = key_item.key_size;
                    nr_next       = nr_clamped;
                    key_q_next    = {key_item.key_w0, key_item.key_w1,
                                     key_item.key_w2, key_item.key_w3};
                end
            end
            aeske_pkg::ST_GEN:
            begin
                if (step)
                begin
                    word_cnt_next = word_cnt_reg + 6'd1;
                    pos_next      = (pos_reg == nk_last) ? 3'd0 : pos_reg + 3'd1;
                    key_q_next    = {key_q_reg[223:0], 32'h00000000};
                    win_next      = {win_reg[223:0], new_word};
                    quad_next     = {quad_reg[63:0], new_word};
                    if (word_cnt_reg >= nk && pos_reg == 3'd0)
                    begin
                        rcon_next = aeske_pkg::gf_double(rcon_reg);
                    end
                    // round key complete: load the output register
                    if (quad_end)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.round_index  = word_cnt_reg[5:2];
                        out_next.round_key_hi = quad_reg[95:32];
                        out_next.round_key_lo = {quad_reg[31:0], new_word};
                        out_next.last_key     = last_quad;
                    end
                    if (last_quad)
                    begin
                        state_next = aeske_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = aeske_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aeske_pkg::ST_IDLE;
            word_cnt_reg  <= 6'd0;
            pos_reg       <= 3'd0;
            rcon_reg      <= aeske_pkg::RCON_FIRST;
            size_reg      <= aeske_pkg::KEY_128;
            nr_reg        <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            pos_reg       <= pos_next;
            rcon_reg      <= rcon_next;
            size_reg      <= size_next;
            nr_reg        <= nr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_q_reg <= key_q_next;
        win_reg   <= win_next;
        quad_reg  <= quad_next;
        out_reg   <= out_next;
    end

`ifndef ASSERT_OFF
    a_load_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (step && quad_end) |=> out_valid_reg)
        else $error("round key not presented after quad end");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aeske_pkg::ST_GEN) |-> (word_cnt_reg < 6'd60))
        else $error("word counter beyond schedule length");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aeske_pkg::ST_GEN) |-> (pos_reg <= nk_last))
        else $error("word position beyond key length");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        key_xfer |=> (state_reg == aeske_pkg::ST_GEN && word_cnt_reg == 6'd0))
        else $error("schedule did not start on key transfer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rkey_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled round key changed");
`endif

endmodule

[test/tb_aes_key_expansion_unit.sv]
module tb_aes_key_expansion_unit;

    localparam int         CLK_HALF         = 6;
    localparam int         RESET_CYCLES     = 5;
    localparam int         RANDOM_PER_PHASE = 66;
    localparam int         STALL_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES     = 16;
    localparam logic [1:0] KEY_256_ALIAS    = 2'd3;
    localparam logic [7:0] SBOX_AFFINE      = 8'h63;

    // fips-197 example keys
    localparam logic [63:0] K128_W0 = 64'h2b7e151628aed2a6;
    localparam logic [63:0] K128_W1 = 64'habf7158809cf4f3c;
    localparam logic [63:0] K192_W0 = 64'h8e73b0f7da0e6452;
    localparam logic [63:0] K192_W1 = 64'hc810f32b809079e5;
    localparam logic [63:0] K192_W2 = 64'h62f8ead2522c6b7b;
    localparam logic [63:0] K256_W0 = 64'h603deb1015ca71be;
    localparam logic [63:0] K256_W1 = 64'h2b73aef0857d7781;
    localparam logic [63:0] K256_W2 = 64'h1f352c073b6108d7;
    localparam logic [63:0] K256_W3 = 64'h2d9810a30914dff4;
    localparam logic [63:0] ONES    = '1;
    localparam logic [63:0] ZEROS   = '0;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  key_valid  = 1'b0;
    logic                  key_stall;
    aeske_pkg::key_item_t  key_item   = '0;
    logic                  rkey_valid;
    logic                  rkey_stall = 1'b0;
    aeske_pkg::rkey_item_t rkey_item;

    aeske_pkg::key_item_t  pending_keys[$];
    aeske_pkg::rkey_item_t expected_rkeys[$];
    logic [7:0] sbox_lut[256];
    int         tx_idle_pct   = 7;
    int         rx_idle_pct   = 51;
    logic       key_accepted  = 1'b0;
    int         keys_planned  = 0;
    int         keys_accepted = 0;
    int         rkeys_checked = 0;
    int         error_count   = 0;
    int         idle_cycles   = 0;
    int         size_seen[4]  = '{0, 0, 0, 0};

    always #CLK_HALF clk = ~clk;

    aes_key_expansion_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_item   (key_item),
        .rkey_valid (rkey_valid),
        .rkey_stall (rkey_stall),
        .rkey_item  (rkey_item)
    );

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? aeske_pkg::GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        prod = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                prod ^= a;
            a = xtime(a);
        end
        return prod;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    // s-box from field inverse (a^254) followed by the affine map
    task automatic build_sbox();
        logic [7:0] inv;
        logic [7:0] x;
        for (int a = 0; a < 256; a++)
        begin
            x   = a[7:0];
            inv = 8'h01;
            repeat (254) inv = gf_mul(inv, x);
            sbox_lut[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ SBOX_AFFINE;
        end
    endtask

    // expand one key and queue the round keys it should produce
    task automatic expand_key_schedule(input aeske_pkg::key_item_t k);
        int unsigned nk;
        int unsigned nr;
        logic [31:0] key_words[8];
        logic [31:0] sched[64];
        logic [31:0] tmp;
        logic [7:0]  rcon;
        aeske_pkg::rkey_item_t rk;
        nk = (k.key_size == aeske_pkg::KEY_128) ? 4
           : (k.key_size == aeske_pkg::KEY_192) ? 6 : 8;
        nr = k.rounds;
        if (nr > nk + 6)
            nr = nk + 6;
        key_words = '{k.key_w0[63:32], k.key_w0[31:0], k.key_w1[63:32], k.key_w1[31:0],
                      k.key_w2[63:32], k.key_w2[31:0], k.key_w3[63:32], k.key_w3[31:0]};
        rcon = aeske_pkg::RCON_FIRST;
        for (int unsigned i = 0; i < 4 * (nr + 1); i++)
        begin
            if (i < nk)
                sched[i] = key_words[i];
            else
            begin
                tmp = sched[i - 1];
                if (i % nk == 0)
                begin
                    tmp  = sbox_word({tmp[23:0], tmp[31:24]}) ^ {rcon, 24'h0};
                    rcon = xtime(rcon);
                end
                else if (nk == 8 && i % 8 == 4)
                    tmp = sbox_word(tmp);
                sched[i] = sched[i - nk] ^ tmp;
            end
            if (i % 4 == 3)
            begin
                rk.round_index  = 4'(i / 4);
                rk.round_key_hi = {sched[i - 3], sched[i - 2]};
                rk.round_key_lo = {sched[i - 1], sched[i]};
                rk.last_key     = (i / 4 == nr);
                expected_rkeys.push_back(rk);
            end
        end
    endtask

    task automatic add_key(input logic [1:0] size, input logic [3:0] nr,
                           input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
        aeske_pkg::key_item_t k;
        k.key_size = size;
        k.rounds   = nr;
        k.key_w0   = w0;
        k.key_w1   = w1;
        k.key_w2   = w2;
        k.key_w3   = w3;
        pending_keys.push_back(k);
        keys_planned++;
    endtask

    // mostly round counts near the standard ones, some anywhere in the field
    task automatic add_random_keys(input int count);
        logic [3:0] nr;
        repeat (count)
        begin
            if ($urandom_range(0, 3) != 0)
                nr = 4'($urandom_range(10, 15));
            else
                nr = 4'($urandom_range(0, 15));
            add_key(2'($urandom_range(0, 3)), nr, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(keys_accepted == keys_planned && expected_rkeys.size() == 0));
    endtask

    // driver: hold a stalled transfer, otherwise offer the next key or idle
    always @(negedge clk)
    begin
        rkey_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        if (rst_n && !(key_valid && !key_accepted))
        begin
            if (pending_keys.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                key_item  <= pending_keys.pop_front();
                key_valid <= 1'b1;
            end
            else
                key_valid <= 1'b0;
        end
    end

    // monitor: predict on key transfers, check round key transfers, watchdog
    always @(posedge clk)
    begin : monitor
        aeske_pkg::rkey_item_t want;
        key_accepted <= rst_n && key_valid && !key_stall;
        if (rst_n && key_valid && !key_stall)
        begin
            expand_key_schedule(key_item);
            keys_accepted++;
            size_seen[key_item.key_size]++;
        end
        if (rst_n && rkey_valid && !rkey_stall)
        begin
            if (expected_rkeys.size() == 0)
            begin
                $error("unexpected round key transfer, round_index %0d", rkey_item.round_index);
                error_count++;
            end
            else
            begin
                want = expected_rkeys.pop_front();
                rkeys_checked++;
                if (rkey_item.round_index !== want.round_index)
                begin
                    $error("round_index: expected %0d, got %0d",
                           want.round_index, rkey_item.round_index);
                    error_count++;
                end
                if (rkey_item.round_key_hi !== want.round_key_hi)
                begin
                    $error("round_key_hi: expected %h, got %h",
                           want.round_key_hi, rkey_item.round_key_hi);
                    error_count++;
                end
                if (rkey_item.round_key_lo !== want.round_key_lo)
                begin
                    $error("round_key_lo: expected %h, got %h",
                           want.round_key_lo, rkey_item.round_key_lo);
                    error_count++;
                end
                if (rkey_item.last_key !== want.last_key)
                begin
                    $error("last_key: expected %b, got %b", want.last_key, rkey_item.last_key);
                    error_count++;
                end
            end
        end
        if ((key_valid && !key_stall) || (rkey_valid && !rkey_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL aes_key_expansion_unit");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        build_sbox();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles rarely, receiver stalls often
        @(posedge clk);
        add_key(aeske_pkg::KEY_128, aeske_pkg::MAX_NR_128, K128_W0, K128_W1, ONES, ONES);
        add_key(aeske_pkg::KEY_192, aeske_pkg::MAX_NR_192, K192_W0, K192_W1, K192_W2, ONES);
        add_key(aeske_pkg::KEY_256, aeske_pkg::MAX_NR_256, K256_W0, K256_W1, K256_W2, K256_W3);
        add_key(aeske_pkg::KEY_128, aeske_pkg::MAX_NR_128, ZEROS, ZEROS, ZEROS, ZEROS);
        add_key(aeske_pkg::KEY_128, aeske_pkg::MAX_NR_128, ONES, ONES, ONES, ONES);
        add_key(aeske_pkg::KEY_192, aeske_pkg::MAX_NR_192, ZEROS, ZEROS, ZEROS, ZEROS);
        add_key(aeske_pkg::KEY_192, aeske_pkg::MAX_NR_192, ONES, ONES, ONES, ONES);
        add_key(aeske_pkg::KEY_256, aeske_pkg::MAX_NR_256, ZEROS, ZEROS, ZEROS, ZEROS);
        add_key(aeske_pkg::KEY_256, aeske_pkg::MAX_NR_256, ONES, ONES, ONES, ONES);
        // size code 3 behaves as a 256-bit key
        add_key(KEY_256_ALIAS, aeske_pkg::MAX_NR_256, K256_W0, K256_W1, K256_W2, K256_W3);
        add_key(KEY_256_ALIAS, 4'd15, ONES, ONES, ONES, ONES);
        // round counts above the maximum get clamped
        add_key(aeske_pkg::KEY_128, 4'd15, K128_W0, K128_W1, ZEROS, ZEROS);
        add_key(aeske_pkg::KEY_128, 4'd11, K128_W0, K128_W1, ZEROS, ZEROS);
        add_key(aeske_pkg::KEY_192, 4'd15, K192_W0, K192_W1, K192_W2, ZEROS);
        add_key(aeske_pkg::KEY_256, 4'd15, K256_W0, K256_W1, K256_W2, K256_W3);
        // short schedules, down to the key itself
        add_key(aeske_pkg::KEY_128, 4'd0, K128_W0, K128_W1, ONES, ONES);
        add_key(aeske_pkg::KEY_192, 4'd0, K192_W0, K192_W1, K192_W2, ONES);
        add_key(aeske_pkg::KEY_256, 4'd0, K256_W0, K256_W1, K256_W2, K256_W3);
        add_key(aeske_pkg::KEY_192, 4'd1, K192_W0, K192_W1, K192_W2, ZEROS);
        add_key(aeske_pkg::KEY_192, 4'd5, ONES, ZEROS, ONES, ZEROS);
        add_key(aeske_pkg::KEY_256, 4'd7, ZEROS, ONES, ZEROS, ONES);
        add_random_keys(RANDOM_PER_PHASE);
        wait_drained();

        // sender idles often, receiver stalls rarely
        @(posedge clk);
        tx_idle_pct = 51;
        rx_idle_pct = 7;
        add_random_keys(RANDOM_PER_PHASE);
        wait_drained();

        // back to back, no idling on either side
        @(posedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_keys(RANDOM_PER_PHASE);
        wait_drained();

        // catch any stray round key after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_rkeys.size() != 0)
        begin
            $error("%0d round keys never arrived", expected_rkeys.size());
            error_count++;
        end

        $display("keys expanded: %0d (128-bit %0d, 192-bit %0d, 256-bit %0d, code 3 %0d)",
                 keys_accepted, size_seen[0], size_seen[1], size_seen[2], size_seen[3]);
        $display("round keys compared: %0d across three idle/stall profiles", rkeys_checked);
        if (error_count == 0)
            $display("PASS aes_key_expansion_unit");
        else
            $display("FAIL aes_key_expansion_unit");
        $finish;
    end

endmodule
